// ===== hdl/usgp_pkg.sv =====
// Shared types, register codes and constant tables for the UV sphere vertex generator.
`timescale 1ns / 1ps
package usgp_pkg;

	typedef struct packed {
		logic [7:0] stack_index;
		logic [7:0] sector_index;
	} point_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] vertex_index;
		logic [15:0] below_index;
		logic upper_triangle;
		logic lower_triangle;
	} vertex_t;

	// Mesh connectivity that rides alongside the arithmetic pipeline.
	typedef struct packed {
		logic [15:0] vertex_index;
		logic [15:0] below_index;
		logic upper_triangle;
		logic lower_triangle;
	} side_t;

	typedef struct packed {
		logic [15:0] tex_u;
		logic [15:0] tex_v;
	} tex_t;

	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_SECTORS = 2'd1;
	localparam logic [1:0] REG_STACKS  = 2'd2;

	localparam int CFG_W   = 15;
	localparam int DIV_W   = 42;
	localparam int DIV_LAT = DIV_W / 2;

	localparam logic [33:0] GAIN_Q30 = 34'd652032874;

	function automatic logic [29:0] atan_phase(input logic [4:0] k);
		logic [29:0] a;
		case (k)
			5'd0:  a = 30'd536870912;
			5'd1:  a = 30'd316933406;
			5'd2:  a = 30'd167458907;
			5'd3:  a = 30'd85004756;
			5'd4:  a = 30'd42667331;
			5'd5:  a = 30'd21354465;
			5'd6:  a = 30'd10679838;
			5'd7:  a = 30'd5340245;
			5'd8:  a = 30'd2670163;
			5'd9:  a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			5'd24: a = 30'd41;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/usgp_div.sv =====
// Pipelined restoring divider by an 8-bit divisor, two quotient bits per stage.
`timescale 1ns / 1ps
module usgp_div
	import usgp_pkg::*;
(
	input  logic             clk,
	input  logic [DIV_W-1:0] num,
	input  logic [7:0]       den,
	output logic [DIV_W-1:0] quo
);

	logic [7:0]       rem_s [0:DIV_LAT];
	logic [DIV_W-1:0] num_s [0:DIV_LAT];
	logic [DIV_W-1:0] quo_s [0:DIV_LAT];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
		logic [8:0] t1, t2;
		logic [7:0] r1, r2;
		logic       q1, q2;

		always_comb begin
			t1 = {rem_s[g], num_s[g][DIV_W-1]};
			q1 = (t1 >= {1'b0, den});
			r1 = q1 ? 8'(t1 - {1'b0, den}) : t1[7:0];
			t2 = {r1, num_s[g][DIV_W-2]};
			q2 = (t2 >= {1'b0, den});
			r2 = q2 ? 8'(t2 - {1'b0, den}) : t2[7:0];
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= r2;
			num_s[g+1] <= {num_s[g][DIV_W-3:0], 2'b00};
			quo_s[g+1] <= {quo_s[g][DIV_W-3:0], q1, q2};
		end
	end

	assign quo = quo_s[DIV_LAT];

endmodule

// ===== hdl/usgp_cordic.sv =====
// Rotation-mode CORDIC pipe: Q1.30 cosine and sine of 32-bit phase, 2^32 per turn.
`timescale 1ns / 1ps
module usgp_cordic
	import usgp_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	logic signed [33:0] x_s [0:STEPS];
	logic signed [33:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	logic               flip_s [0:STEPS];
	logic               flip;
	logic [31:0]        ph_adj;

	// Phases in the left half-plane are turned by half a turn and the result negated.
	assign flip   = phase[31] ^ phase[30];
	assign ph_adj = flip ? (phase + 32'h8000_0000) : phase;

	always_ff @(posedge clk) begin
		flip_s[0] <= flip;
		x_s[0]    <= signed'(GAIN_Q30);
		y_s[0]    <= '0;
		z_s[0]    <= 34'(signed'(ph_adj));
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_iter
		logic signed [33:0] a;
		assign a = signed'(34'(atan_phase(5'(k))));

		always_ff @(posedge clk) begin
			flip_s[k+1] <= flip_s[k];
			if (z_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - a;
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + a;
			end
		end
	end

	always_ff @(posedge clk) begin
		cos_val <= flip_s[STEPS] ? 32'(-x_s[STEPS]) : 32'(x_s[STEPS]);
		sin_val <= flip_s[STEPS] ? 32'(-y_s[STEPS]) : 32'(y_s[STEPS]);
	end

endmodule

// ===== hdl/uv_sphere_grid_point.sv =====
// Top level: UV sphere vertex generator, one grid point in and one vertex out per beat.
//
//  channel  | signals                                 | flow
//  ---------+-----------------------------------------+--------------------------------
//  point    | start, busy, point                      | beat when start high, busy low
//  vertex   | vertex_valid, vertex                    | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data             | write on any edge with cfg_we high
//
// A point is accepted every cycle; busy never rises.
// The pipeline has 21 divider stages (two quotient bits each),
// CORDIC_STEPS + 2 CORDIC stages, then four multiply and rounding stages.
// Reset clears the valid bits and loads the default radius and counts.
// The receiver cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps
module uv_sphere_grid_point
	import usgp_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  point_t           point,
	output logic             vertex_valid,
	output vertex_t          vertex,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CORD_LAT = CORDIC_STEPS + 2;
	localparam int SB_LAT   = DIV_LAT + CORD_LAT + 3;
	localparam int TEX_LAT  = CORD_LAT + 3;

	function automatic logic signed [15:0] sat_lim(input logic signed [63:0] v,
		input logic signed [63:0] lim_lo, input logic signed [63:0] lim_hi);
		logic signed [63:0] c;
		c = (v < lim_lo) ? lim_lo : ((v > lim_hi) ? lim_hi : v);
		return c[15:0];
	endfunction

	logic [14:0] radius_q;
	logic [7:0]  sectors_q, stacks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 15'd256;
			sectors_q <= 8'd16;
			stacks_q  <= 8'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:  radius_q  <= cfg_data;
				REG_SECTORS: sectors_q <= cfg_data[7:0];
				REG_STACKS:  stacks_q  <= cfg_data[7:0];
				default:     ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic       accept;
	logic [7:0] sectors, stacks, i_c, j_c;
	logic [16:0] vidx, bidx;
	logic       quad;
	side_t      sb_in;

	assign accept  = start && !busy;
	assign sectors = (sectors_q < 8'd3) ? 8'd3 : sectors_q;
	assign stacks  = (stacks_q < 8'd2) ? 8'd2 : stacks_q;
	assign i_c     = (point.stack_index > stacks) ? stacks : point.stack_index;
	assign j_c     = (point.sector_index > sectors) ? sectors : point.sector_index;
	assign vidx    = 17'(i_c) * (17'(sectors) + 17'd1) + 17'(j_c);
	assign bidx    = vidx + 17'(sectors) + 17'd1;
	assign quad    = (i_c < stacks) && (j_c < sectors);

	always_comb begin
		sb_in.vertex_index   = vidx[15:0];
		sb_in.below_index    = quad ? bidx[15:0] : 16'd0;
		sb_in.upper_triangle = quad && (i_c != 8'd0);
		sb_in.lower_triangle = quad && (i_c != 8'(stacks - 8'd1));
	end

	// Angle and texture quotients, each rounded by adding half the divisor.
	logic [DIV_W-1:0] q_th, q_ph, q_u, q_v;

	usgp_div u_div_th (.clk, .num(DIV_W'({j_c, 32'd0}) + DIV_W'(sectors >> 1)),
		.den(sectors), .quo(q_th));
	usgp_div u_div_ph (.clk, .num(DIV_W'({i_c, 31'd0}) + DIV_W'(stacks >> 1)),
		.den(stacks), .quo(q_ph));
	usgp_div u_div_u (.clk, .num(DIV_W'({j_c, 15'd0}) + DIV_W'(sectors >> 1)),
		.den(sectors), .quo(q_u));
	usgp_div u_div_v (.clk, .num(DIV_W'({i_c, 15'd0}) + DIV_W'(stacks >> 1)),
		.den(stacks), .quo(q_v));

	logic [31:0] theta, phi;
	assign theta = q_th[31:0];
	assign phi   = 32'h4000_0000 - q_ph[31:0];

	logic signed [31:0] cp, sp, ct, st;

	usgp_cordic #(.STEPS(CORDIC_STEPS)) u_cord_ph (.clk, .phase(phi), .cos_val(cp),
		.sin_val(sp));
	usgp_cordic #(.STEPS(CORDIC_STEPS)) u_cord_th (.clk, .phase(theta), .cos_val(ct),
		.sin_val(st));

	// Valid bits and connectivity follow the arithmetic down the pipe.
	logic [SB_LAT:1] vld_s;
	side_t           sb_s  [1:SB_LAT];
	tex_t            tex_s [1:TEX_LAT];
	tex_t            tex_in;

	assign tex_in.tex_u = q_u[15:0];
	assign tex_in.tex_v = q_v[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SB_LAT-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		sb_s[1]  <= sb_in;
		tex_s[1] <= tex_in;
		for (int n = 2; n <= SB_LAT; n++) begin
			sb_s[n] <= sb_s[n-1];
		end
		for (int n = 2; n <= TEX_LAT; n++) begin
			tex_s[n] <= tex_s[n-1];
		end
	end

	logic signed [15:0] r_w;
	assign r_w = signed'({1'b0, radius_q});

	logic signed [47:0] rcp_s1, rsp_s1;
	logic signed [63:0] ncx_s1, ncy_s1;
	logic signed [31:0] sp_s1, ct_s1, st_s1, ct_s2, st_s2;
	logic signed [47:0] xy_w;
	logic signed [33:0] xy_s2;
	logic signed [15:0] pz_s2, nx_s2, ny_s2, nz_s2, pz_s3, nx_s3, ny_s3, nz_s3;
	logic signed [63:0] px_s3, py_s3;

	always_ff @(posedge clk) begin
		rcp_s1 <= r_w * cp;
		rsp_s1 <= r_w * sp;
		ncx_s1 <= cp * ct;
		ncy_s1 <= cp * st;
		sp_s1  <= sp;
		ct_s1  <= ct;
		st_s1  <= st;
	end

	assign xy_w = (rcp_s1 + 48'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		xy_s2 <= 34'(xy_w);
		ct_s2 <= ct_s1;
		st_s2 <= st_s1;
		pz_s2 <= sat_lim(64'((rsp_s1 + (48'sd1 <<< 29)) >>> 30), -64'sd32768, 64'sd32767);
		nx_s2 <= sat_lim((ncx_s1 + (64'sd1 <<< 45)) >>> 46, -64'sd16384, 64'sd16384);
		ny_s2 <= sat_lim((ncy_s1 + (64'sd1 <<< 45)) >>> 46, -64'sd16384, 64'sd16384);
		nz_s2 <= sat_lim(64'((sp_s1 + 32'sd32768) >>> 16), -64'sd16384, 64'sd16384);
	end

	always_ff @(posedge clk) begin
		px_s3 <= xy_s2 * ct_s2;
		py_s3 <= xy_s2 * st_s2;
		pz_s3 <= pz_s2;
		nx_s3 <= nx_s2;
		ny_s3 <= ny_s2;
		nz_s3 <= nz_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid <= 1'b0;
		end else begin
			vertex_valid <= vld_s[SB_LAT];
		end
	end

	always_ff @(posedge clk) begin
		vertex.pos_x <= sat_lim((px_s3 + (64'sd1 <<< 45)) >>> 46, -64'sd32768, 64'sd32767);
		vertex.pos_y <= sat_lim((py_s3 + (64'sd1 <<< 45)) >>> 46, -64'sd32768, 64'sd32767);
		vertex.pos_z          <= pz_s3;
		vertex.normal_x       <= nx_s3;
		vertex.normal_y       <= ny_s3;
		vertex.normal_z       <= nz_s3;
		vertex.tex_u          <= tex_s[TEX_LAT].tex_u;
		vertex.tex_v          <= tex_s[TEX_LAT].tex_v;
		vertex.vertex_index   <= sb_s[SB_LAT].vertex_index;
		vertex.below_index    <= sb_s[SB_LAT].below_index;
		vertex.upper_triangle <= sb_s[SB_LAT].upper_triangle;
		vertex.lower_triangle <= sb_s[SB_LAT].lower_triangle;
	end

endmodule

// ===== hdl/usgp_check.sv =====
// Port-level checks for the UV sphere vertex generator, bound to the top level.
`timescale 1ns / 1ps
module usgp_check
	import usgp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    busy,
	input logic    vertex_valid,
	input vertex_t vertex
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although every point is taken");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> (vertex.tex_u <= 16'd32768) && (vertex.tex_v <= 16'd32768))
		else $error("texture coordinate above one");

	a_no_quad: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && (vertex.below_index == 16'd0)
		|-> !vertex.upper_triangle && !vertex.lower_triangle)
		else $error("triangle flagged without a quad");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> (vertex.normal_x >= -16'sd16384) && (vertex.normal_x <= 16'sd16384)
		&& (vertex.normal_z >= -16'sd16384) && (vertex.normal_z <= 16'sd16384))
		else $error("normal component outside unit range");

endmodule

bind uv_sphere_grid_point usgp_check u_check (.*);

// ===== tb/sv/uv_sphere_grid_point_tb.sv =====
// Self-checking testbench for the UV sphere vertex generator: grid points in, vertices checked.
`timescale 1ns / 1ps
module uv_sphere_grid_point_tb;
	import usgp_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 27;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint ARCTAN [25] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic vertex_valid;
	vertex_t vertex;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_RADIUS;
	logic [CFG_W-1:0] cfg_data = '0;

	// Register copies held by the predictor.
	longint radius_q88 = 256;
	longint sectors_raw = 16;
	longint stacks_raw = 16;

	point_t pending_points[$];
	vertex_t expected_vertices[$];
	int mismatches = 0;
	longint cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	uv_sphere_grid_point #(.CORDIC_STEPS(STEPS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.vertex_valid(vertex_valid), .vertex(vertex),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint round_shr(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Rotation-mode CORDIC over a 32-bit phase where one turn is 2^32.
	function automatic void rotate_phase(input logic [31:0] ph, output longint c,
			output longint s);
		logic flip;
		longint x, y, z, dx, dy;
		flip = ph[30] ^ ph[31];
		if (flip) begin
			ph = ph + 32'h8000_0000;
		end
		z = longint'($signed(ph));
		x = 652032874;
		y = 0;
		for (int k = 0; k < STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[k];
			end else begin
				x += dx; y -= dy; z += ARCTAN[k];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic vertex_t sphere_vertex(input point_t p);
		vertex_t v;
		longint sectors, stacks, i, j, cp, sp, ct, st, xy, vidx;
		logic [31:0] theta, phi;
		sectors = sectors_raw < 3 ? 3 : sectors_raw;
		stacks = stacks_raw < 2 ? 2 : stacks_raw;
		i = p.stack_index;
		j = p.sector_index;
		if (i > stacks) i = stacks;
		if (j > sectors) j = sectors;
		theta = 32'(((j << 32) + sectors / 2) / sectors);
		phi = 32'h4000_0000 - 32'(((i << 31) + stacks / 2) / stacks);
		rotate_phase(phi, cp, sp);
		rotate_phase(theta, ct, st);
		xy = round_shr(radius_q88 * cp, 14);
		v.pos_x = 16'(clip(round_shr(xy * ct, 46), -32768, 32767));
		v.pos_y = 16'(clip(round_shr(xy * st, 46), -32768, 32767));
		v.pos_z = 16'(clip(round_shr(radius_q88 * sp, 30), -32768, 32767));
		v.normal_x = 16'(clip(round_shr(cp * ct, 46), -16384, 16384));
		v.normal_y = 16'(clip(round_shr(cp * st, 46), -16384, 16384));
		v.normal_z = 16'(clip(round_shr(sp, 16), -16384, 16384));
		v.tex_u = 16'((j * 32768 + sectors / 2) / sectors);
		v.tex_v = 16'((i * 32768 + stacks / 2) / stacks);
		vidx = i * (sectors + 1) + j;
		v.vertex_index = 16'(vidx);
		v.below_index = '0;
		v.upper_triangle = 1'b0;
		v.lower_triangle = 1'b0;
		if (i < stacks && j < sectors) begin
			v.below_index = 16'(vidx + sectors + 1);
			v.upper_triangle = i != 0;
			v.lower_triangle = i != stacks - 1;
		end
		return v;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_vertices = {expected_vertices, sphere_vertex(point)};
		end
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_points.size() > 0) begin
			point <= pending_points.pop_front();
			start <= 1'b1;
			if (burst_left > 0) begin
				burst_left <= burst_left - 1;
			end else begin
				burst_left <= $urandom_range(0, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		vertex_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (vertex_valid) begin
			if (expected_vertices.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected vertex beat %p", vertex);
			end else begin
				want = expected_vertices.pop_front();
				if (want !== vertex) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("vertex mismatch: expected %p got %p", want, vertex);
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_RADIUS: radius_q88 = data;
			REG_SECTORS: sectors_raw = data[7:0];
			REG_STACKS: stacks_raw = data[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (!(pending_points.size() == 0 && !start && expected_vertices.size() == 0)) begin
			@(posedge clk);
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic queue_point(input int i, input int j);
		point_t p;
		p.stack_index = 8'(i);
		p.sector_index = 8'(j);
		pending_points = {pending_points, p};
	endtask

	task automatic queue_random(input int n);
		int sec, stk;
		sec = int'(sectors_raw < 3 ? 3 : sectors_raw);
		stk = int'(stacks_raw < 2 ? 2 : stacks_raw);
		// Most points lie on the grid; the rest exercise clamping over the full range.
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_point($urandom_range(0, 255), $urandom_range(0, 255));
			end else begin
				queue_point($urandom_range(0, stk), $urandom_range(0, sec));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Poles, seams, last row and column, and indices beyond the counts.
		queue_point(0, 0); queue_point(16, 0); queue_point(0, 16); queue_point(16, 16);
		queue_point(15, 15); queue_point(1, 0); queue_point(8, 4); queue_point(8, 12);
		queue_point(4, 8); queue_point(255, 255); queue_point(255, 0); queue_point(0, 255);
		queue_point(17, 17); queue_point(170, 85); queue_point(85, 170); queue_point(15, 16);
		drain();

		write_reg(REG_RADIUS, 15'd32767);
		write_reg(REG_SECTORS, 15'd255);
		write_reg(REG_STACKS, 15'd255);
		queue_point(0, 0); queue_point(255, 255); queue_point(254, 254); queue_point(128, 64);
		queue_point(127, 191);
		queue_random(200);
		drain();

		write_reg(REG_RADIUS, 15'd0);
		write_reg(REG_SECTORS, 15'd0);
		write_reg(REG_STACKS, 15'd1);
		queue_point(0, 0); queue_point(1, 2); queue_point(2, 3); queue_point(3, 4);
		queue_random(100);
		drain();

		write_reg(REG_RADIUS, 15'd1);
		write_reg(REG_SECTORS, 15'h7f03);
		write_reg(REG_STACKS, 15'h7f02);
		write_reg(REG_UNUSED, 15'h7fff);
		queue_random(150);
		drain();

		write_reg(REG_SECTORS, 15'd2);
		write_reg(REG_STACKS, 15'd0);
		write_reg(REG_RADIUS, 15'h2aaa);
		queue_random(100);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_RADIUS, 15'($urandom_range(0, 32767)));
			write_reg(REG_SECTORS, 15'($urandom_range(0, 32767)));
			write_reg(REG_STACKS, 15'($urandom_range(0, 32767)));
			if (ph[0]) write_reg(REG_UNUSED, 15'($urandom_range(0, 32767)));
			queue_random(140);
			drain();
		end

		if (expected_vertices.size() == 0 && mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/usgp_pkg.sv
hdl/usgp_div.sv
hdl/usgp_cordic.sv
hdl/uv_sphere_grid_point.sv
hdl/usgp_check.sv
tb/sv/uv_sphere_grid_point_tb.sv
